/* hdl/ftdr_pkg.sv */
// shared types, constants and the per-level duty table of the fan regulator
package ftdr_pkg;

    // number of speed levels; the target table holds one more entry
    localparam int LEVELS     = 10;
    localparam int TGT_DEPTH  = LEVELS + 1;
    localparam int TGT_IDX_W  = $clog2(TGT_DEPTH);

    // field widths
    localparam int DUTY_W     = 12;
    localparam int RPM_W      = 16;
    localparam int ACC_W      = 20;
    localparam int WIN_W      = 16;
    localparam int PPR_W      = 8;
    localparam int TOL_W      = 12;
    localparam int LVL_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // serial divider: dividend is pulses*60, one quotient bit a cycle
    localparam int DVD_W      = ACC_W + 6;
    localparam int CNT_W      = $clog2(DVD_W);
    localparam int REM_W      = PPR_W + 1;

    // defaults
    localparam logic [PPR_W-1:0]  PPR_DEFAULT  = PPR_W'(15);
    localparam logic [TOL_W-1:0]  TOL_DEFAULT  = TOL_W'(50);
    localparam logic [WIN_W-1:0]  WIN_DEFAULT  = WIN_W'(1000);
    localparam logic [DUTY_W-1:0] DMAX_DEFAULT = DUTY_W'(1000);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PPR  = 2'd0,
        CFG_TOL  = 2'd1,
        CFG_WIN  = 2'd2,
        CFG_DMAX = 2'd3
    } t_cfg_reg;

    // item function codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_SAT,
        S_ERR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                 func;
        logic [3:0]           fg_pulses;
        logic                 fan_on;
        logic [LVL_W-1:0]     speed_level;
        logic                 test_mode;
        logic [3:0]           entry_index;
        logic [RPM_W-1:0]     entry_rpm;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_W-1:0]    duty;
        logic                 duty_update;
        logic [RPM_W-1:0]     fan_rpm;
        logic                 rpm_ready;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_item;

    // fixed duty per level, last entry serves every higher level
    function automatic logic [DUTY_W-1:0] level_duty(input logic [LVL_W-1:0] lvl);
        logic [DUTY_W-1:0] d;
        case (lvl)
            4'd0:    d = DUTY_W'(700);
            4'd1:    d = DUTY_W'(660);
            4'd2:    d = DUTY_W'(615);
            4'd3:    d = DUTY_W'(510);
            4'd4:    d = DUTY_W'(440);
            4'd5:    d = DUTY_W'(375);
            4'd6:    d = DUTY_W'(315);
            4'd7:    d = DUTY_W'(250);
            4'd8:    d = DUTY_W'(179);
            default: d = DUTY_W'(118);
        endcase
        return d;
    endfunction

endpackage

/* hdl/ftdr_if.sv */
// valid/ready channel interfaces for items, results and configuration writes
interface ftdr_in_if;
    logic               valid;
    logic               ready;
    ftdr_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ftdr_out_if;
    logic                valid;
    logic                ready;
    ftdr_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ftdr_cfg_if;
    logic                valid;
    logic                ready;
    ftdr_pkg::t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/fan_tach_duty_regulator.sv */
// fan speed regulator: tach measurement with serial divider and duty stepping
//
//  channel   dir  payload                                   transfer when
//  i_in      in   func, fg_pulses, fan_on, speed_level,     valid & ready
//                 test_mode, entry_index, entry_rpm
//  o_out     out  duty, duty_update, fan_rpm, rpm_ready     valid & ready
//  i_cfg     in   index, data                               valid & ready
//
// a table write or a tick that closes no window passes from transfer through the
// prep and output states; a tick that closes a window also runs the divider,
// saturation and error states, the bit-serial divider producing one of 26 quotient bits per cycle
// reset is synchronous, active low; the target table clears to zero at once
// the result sits in an output register, so a stalled sink holds only the
// next item's final step; the config port is always ready
module fan_tach_duty_regulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ftdr_in_if.sink     i_in,
    ftdr_out_if.source  o_out,
    ftdr_cfg_if.sink    i_cfg
);

    ftdr_pkg::t_state r_state, n_state;

    // configuration
    logic [ftdr_pkg::PPR_W-1:0]  r_ppr;
    logic [ftdr_pkg::TOL_W-1:0]  r_tol;
    logic [ftdr_pkg::WIN_W-1:0]  r_win;
    logic [ftdr_pkg::DUTY_W-1:0] r_dmax;

    // regulator state
    logic [ftdr_pkg::RPM_W-1:0]  r_tgt [ftdr_pkg::TGT_DEPTH];
    logic [ftdr_pkg::ACC_W-1:0]  r_accum;
    logic [ftdr_pkg::WIN_W-1:0]  r_wcount;
    logic [ftdr_pkg::RPM_W-1:0]  r_meas;
    logic [ftdr_pkg::DUTY_W-1:0] r_duty_now;
    logic [ftdr_pkg::DUTY_W-1:0] r_duty_drv;
    logic [ftdr_pkg::LVL_W-1:0]  r_last_lvl;
    logic                        r_last_on;

    // item in flight
    ftdr_pkg::t_in_item          r_in;
    logic [ftdr_pkg::LVL_W-1:0]  r_real;
    logic                        r_close;

    // serial divider
    logic [ftdr_pkg::DVD_W-1:0]  r_dvd;
    logic [ftdr_pkg::REM_W-1:0]  r_rem;
    logic [ftdr_pkg::CNT_W-1:0]  r_cnt;

    // output register
    logic                        r_out_valid;
    ftdr_pkg::t_out_item         r_out;

    // fsm strobes
    logic w_in_ready;
    logic w_out_load;
    logic w_div_last;

    // prep-cycle datapath
    logic [ftdr_pkg::ACC_W:0]    w_sum;
    logic [ftdr_pkg::ACC_W-1:0]  w_acc1;
    logic [ftdr_pkg::WIN_W-1:0]  w_wc1;
    logic [ftdr_pkg::WIN_W-1:0]  w_wlen;
    logic [ftdr_pkg::LVL_W-1:0]  w_lvl;
    logic [ftdr_pkg::LVL_W-1:0]  w_real;
    logic                        w_change;
    logic [ftdr_pkg::DUTY_W-1:0] w_tab_duty;
    logic [ftdr_pkg::DUTY_W-1:0] w_duty1;
    logic [ftdr_pkg::ACC_W-1:0]  w_acc2;
    logic [ftdr_pkg::WIN_W-1:0]  w_wc2;
    logic                        w_close;

    // divider step
    logic [ftdr_pkg::REM_W-1:0]  w_rem_sh;
    logic [ftdr_pkg::REM_W-1:0]  w_ppr_eff;
    logic                        w_qbit;

    // error check
    logic [ftdr_pkg::TGT_IDX_W-1:0] w_tidx;
    logic [ftdr_pkg::RPM_W:0]       w_err;
    logic [ftdr_pkg::RPM_W:0]       w_mag;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ftdr_pkg::S_IDLE: if (i_in.valid) n_state = ftdr_pkg::S_PREP;
            ftdr_pkg::S_PREP: n_state = w_close ? ftdr_pkg::S_DIV : ftdr_pkg::S_OUT;
            ftdr_pkg::S_DIV:  if (w_div_last) n_state = ftdr_pkg::S_SAT;
            ftdr_pkg::S_SAT:  n_state = ftdr_pkg::S_ERR;
            ftdr_pkg::S_ERR:  n_state = ftdr_pkg::S_OUT;
            ftdr_pkg::S_OUT:  if (w_out_load) n_state = ftdr_pkg::S_IDLE;
            default:          n_state = ftdr_pkg::S_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_out_load = 1'b0;
        w_div_last = 1'b0;
        case (r_state)
            ftdr_pkg::S_IDLE: w_in_ready = 1'b1;
            ftdr_pkg::S_DIV:  w_div_last = (r_cnt == ftdr_pkg::CNT_W'(ftdr_pkg::DVD_W - 1));
            ftdr_pkg::S_OUT:  w_out_load = !r_out_valid || o_out.ready;
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // tick bookkeeping: pulse sum, window count, level and on tracking
    always_comb begin
        w_sum      = {1'b0, r_accum} + (ftdr_pkg::ACC_W + 1)'(r_in.fg_pulses);
        w_acc1     = w_sum[ftdr_pkg::ACC_W] ? '1 : w_sum[ftdr_pkg::ACC_W-1:0];
        w_wc1      = (r_wcount != '1) ? r_wcount + 1'b1 : r_wcount;
        w_wlen     = (r_win != '0) ? r_win : ftdr_pkg::WIN_W'(1);
        w_lvl      = (r_in.speed_level >= ftdr_pkg::LVL_W'(ftdr_pkg::LEVELS))
                   ? ftdr_pkg::LVL_W'(ftdr_pkg::LEVELS - 1) : r_in.speed_level;
        w_real     = r_in.fan_on ? w_lvl : '0;
        w_change   = (w_real != r_last_lvl) || (r_in.fan_on != r_last_on);
        w_tab_duty = ftdr_pkg::level_duty(w_real);
        if (w_tab_duty > r_dmax) begin
            w_tab_duty = r_dmax;
        end
        w_duty1 = r_duty_now;
        w_acc2  = w_acc1;
        w_wc2   = w_wc1;
        if (!r_in.test_mode) begin
            if (!r_in.fan_on) begin
                w_duty1 = r_dmax;
            end
            if (w_change) begin
                if (r_in.fan_on) begin
                    w_duty1 = w_tab_duty;
                end
                w_acc2 = '0;
                w_wc2  = '0;
            end
        end
        w_close = (r_in.func == ftdr_pkg::FUNC_TICK) && (w_wc2 >= w_wlen);
    end

    // restoring division step on the remainder
    always_comb begin
        w_ppr_eff = (r_ppr != '0) ? {1'b0, r_ppr} : {1'b0, ftdr_pkg::PPR_DEFAULT};
        w_rem_sh  = {r_rem[ftdr_pkg::REM_W-2:0], r_dvd[ftdr_pkg::DVD_W-1]};
        w_qbit    = (w_rem_sh >= w_ppr_eff);
    end

    // rpm error against the target of the next level
    always_comb begin
        w_tidx = ftdr_pkg::TGT_IDX_W'(r_real) + 1'b1;
        w_err  = {1'b0, r_meas} - {1'b0, r_tgt[w_tidx]};
        w_mag  = w_err[ftdr_pkg::RPM_W] ? (~w_err + 1'b1) : w_err;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ftdr_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ftdr_pkg::S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr  <= ftdr_pkg::PPR_DEFAULT;
            r_tol  <= ftdr_pkg::TOL_DEFAULT;
            r_win  <= ftdr_pkg::WIN_DEFAULT;
            r_dmax <= ftdr_pkg::DMAX_DEFAULT;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                ftdr_pkg::CFG_PPR:  r_ppr  <= i_cfg.data.data[ftdr_pkg::PPR_W-1:0];
                ftdr_pkg::CFG_TOL:  r_tol  <= i_cfg.data.data[ftdr_pkg::TOL_W-1:0];
                ftdr_pkg::CFG_WIN:  r_win  <= i_cfg.data.data[ftdr_pkg::WIN_W-1:0];
                ftdr_pkg::CFG_DMAX: r_dmax <= i_cfg.data.data[ftdr_pkg::DUTY_W-1:0];
                default:            r_ppr  <= r_ppr;
            endcase
        end
    end

    // regulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ftdr_pkg::TGT_DEPTH; k++) begin
                r_tgt[k] <= '0;
            end
            r_accum    <= '0;
            r_wcount   <= '0;
            r_meas     <= '0;
            r_duty_now <= '0;
            r_duty_drv <= '0;
            r_last_lvl <= '0;
            r_last_on  <= 1'b0;
        end else begin
            case (r_state)
                ftdr_pkg::S_PREP: begin
                    if (r_in.func == ftdr_pkg::FUNC_WRITE) begin
                        if (r_in.entry_index <= 4'(ftdr_pkg::LEVELS)) begin
                            r_tgt[ftdr_pkg::TGT_IDX_W'(r_in.entry_index)] <= r_in.entry_rpm;
                        end
                    end else begin
                        r_duty_now <= w_duty1;
                        r_accum    <= w_close ? '0 : w_acc2;
                        r_wcount   <= w_close ? '0 : w_wc2;
                        if (!r_in.test_mode) begin
                            r_last_lvl <= w_real;
                            r_last_on  <= r_in.fan_on;
                        end
                    end
                end
                ftdr_pkg::S_SAT: begin
                    r_meas <= (r_dvd[ftdr_pkg::DVD_W-1:ftdr_pkg::RPM_W] != '0)
                            ? '1 : r_dvd[ftdr_pkg::RPM_W-1:0];
                end
                ftdr_pkg::S_ERR: begin
                    if (!r_in.test_mode && r_in.fan_on
                            && (w_mag >= (ftdr_pkg::RPM_W + 1)'(r_tol))) begin
                        if (!w_err[ftdr_pkg::RPM_W] && (w_err != '0)) begin
                            if (r_duty_now < r_dmax) begin
                                r_duty_now <= r_duty_now + 1'b1;
                            end
                        end else if (r_duty_now != '0) begin
                            r_duty_now <= r_duty_now - 1'b1;
                        end
                    end
                end
                ftdr_pkg::S_OUT: begin
                    if (w_out_load && (r_in.func == ftdr_pkg::FUNC_TICK)
                            && !r_in.test_mode) begin
                        r_duty_drv <= r_duty_now;
                    end
                end
                default: begin
                    r_meas <= r_meas;
                end
            endcase
        end
    end

    // item capture, divider shift register and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_in <= i_in.data;
        end
        if (r_state == ftdr_pkg::S_PREP) begin
            r_real  <= w_real;
            r_close <= w_close;
            // pulses*60 as (x << 6) - (x << 2)
            r_dvd   <= {w_acc2, 6'b0} - ftdr_pkg::DVD_W'({w_acc2, 2'b0});
            r_rem   <= '0;
        end else if (r_state == ftdr_pkg::S_DIV) begin
            r_rem <= w_qbit ? (w_rem_sh - w_ppr_eff) : w_rem_sh;
            r_dvd <= {r_dvd[ftdr_pkg::DVD_W-2:0], w_qbit};
        end
        if (w_out_load) begin
            r_out.duty        <= r_duty_now;
            r_out.duty_update <= (r_in.func == ftdr_pkg::FUNC_TICK) && !r_in.test_mode
                                 && (r_duty_now != r_duty_drv);
            r_out.fan_rpm     <= r_meas;
            r_out.rpm_ready   <= r_close && (r_in.func == ftdr_pkg::FUNC_TICK);
        end
    end

    // an accepted item always starts with the bookkeeping cycle
    a_accept_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == ftdr_pkg::S_PREP))
        else $error("item transfer not followed by prep cycle");

    // the divider never runs past its last quotient bit
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ftdr_pkg::S_DIV) |-> (r_cnt < ftdr_pkg::CNT_W'(ftdr_pkg::DVD_W)))
        else $error("divider counter overran");

    // driven duty moves only when a result is loaded
    a_drv_only_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_out_load |=> $stable(r_duty_drv))
        else $error("driven duty changed outside result load");

    // a fresh result only comes from the output state
    a_out_from_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ftdr_pkg::S_OUT))
        else $error("result appeared outside output state");

endmodule

/* tb/sv/tb_fan_tach_duty_regulator.sv */
`timescale 1ns / 1ps
// self-checking bench for the fan regulator: directed table, random phases, duty/rpm predictor
module tb_fan_tach_duty_regulator;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned RANDOM_ITEMS  = 450;
    localparam int unsigned SETTLE_CYCLES = 40;

    // starting duty for each speed level
    localparam bit [11:0] LEVEL_DUTY [10] = '{700, 660, 615, 510, 440, 375, 315, 250, 179, 118};

    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    // one row of the directed table; want is used only when typed is set
    typedef struct packed {
        t_row_kind            kind;
        ftdr_pkg::t_cfg_reg   creg;
        logic                 func;
        bit [3:0]             pulses;
        bit                   on;
        bit [3:0]             lvl;
        bit                   test;
        bit [3:0]             idx;
        bit [15:0]            val;
        bit                   typed;
        ftdr_pkg::t_out_item  want;
    } t_row;

    localparam t_row DIRECTED [27] = '{
        // after reset: fan off loads the off duty
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_TICK,  4'd0,  1'b0, 4'd0,  1'b0,
          4'd0,  16'd0,    1'b1, '{12'd1000, 1'b1, 16'd0, 1'b0}},
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_WRITE, 4'd0,  1'b0, 4'd0,  1'b0,
          4'd10, 16'hFFFF, 1'b1, '{12'd1000, 1'b0, 16'd0, 1'b0}},
        // write beyond the table is dropped
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_WRITE, 4'd0,  1'b0, 4'd0,  1'b0,
          4'd15, 16'h5A5A, 1'b1, '{12'd1000, 1'b0, 16'd0, 1'b0}},
        // zero window falls back to a single tick, zero pulses-per-rev to its default
        '{ROW_CFG,  ftdr_pkg::CFG_WIN,  ftdr_pkg::FUNC_TICK,  4'd0,  1'b0, 4'd0,  1'b0,
          4'd0,  16'd0,    1'b0, '0},
        '{ROW_CFG,  ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_TICK,  4'd0,  1'b0, 4'd0,  1'b0,
          4'd0,  16'd0,    1'b0, '0},
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_TICK,  4'd15, 1'b0, 4'd0,  1'b0,
          4'd0,  16'd0,    1'b0, '0},
        // level above range taken as the top level
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_TICK,  4'd15, 1'b1, 4'd15, 1'b0,
          4'd0,  16'd0,    1'b0, '0},
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_TICK,  4'd15, 1'b1, 4'd9,  1'b0,
          4'd0,  16'd0,    1'b0, '0},
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_TICK,  4'd10, 1'b1, 4'd3,  1'b1,
          4'd0,  16'd0,    1'b0, '0},
        // level duty clamped by a zero duty limit, no step above it
        '{ROW_CFG,  ftdr_pkg::CFG_DMAX, ftdr_pkg::FUNC_TICK,  4'd0,  1'b0, 4'd0,  1'b0,
          4'd0,  16'd0,    1'b0, '0},
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_TICK,  4'd5,  1'b1, 4'd0,  1'b0,
          4'd0,  16'd0,    1'b0, '0},
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_TICK,  4'd15, 1'b1, 4'd0,  1'b0,
          4'd0,  16'd0,    1'b0, '0},
        // zero tolerance with zero error steps down
        '{ROW_CFG,  ftdr_pkg::CFG_DMAX, ftdr_pkg::FUNC_TICK,  4'd0,  1'b0, 4'd0,  1'b0,
          4'd0,  16'd4095, 1'b0, '0},
        '{ROW_CFG,  ftdr_pkg::CFG_TOL,  ftdr_pkg::FUNC_TICK,  4'd0,  1'b0, 4'd0,  1'b0,
          4'd0,  16'd0,    1'b0, '0},
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_WRITE, 4'd0,  1'b0, 4'd0,  1'b0,
          4'd2,  16'd60,   1'b0, '0},
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_TICK,  4'd0,  1'b1, 4'd1,  1'b0,
          4'd0,  16'd0,    1'b0, '0},
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_TICK,  4'd15, 1'b1, 4'd1,  1'b0,
          4'd0,  16'd0,    1'b0, '0},
        // duty already above the limit stays put on an upward step
        '{ROW_CFG,  ftdr_pkg::CFG_DMAX, ftdr_pkg::FUNC_TICK,  4'd0,  1'b0, 4'd0,  1'b0,
          4'd0,  16'd100,  1'b0, '0},
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_WRITE, 4'd0,  1'b0, 4'd0,  1'b0,
          4'd2,  16'd0,    1'b0, '0},
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_TICK,  4'd15, 1'b1, 4'd1,  1'b0,
          4'd0,  16'd0,    1'b0, '0},
        // register extremes
        '{ROW_CFG,  ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_TICK,  4'd0,  1'b0, 4'd0,  1'b0,
          4'd0,  16'd255,  1'b0, '0},
        '{ROW_CFG,  ftdr_pkg::CFG_TOL,  ftdr_pkg::FUNC_TICK,  4'd0,  1'b0, 4'd0,  1'b0,
          4'd0,  16'd4095, 1'b0, '0},
        '{ROW_CFG,  ftdr_pkg::CFG_WIN,  ftdr_pkg::FUNC_TICK,  4'd0,  1'b0, 4'd0,  1'b0,
          4'd0,  16'hFFFF, 1'b0, '0},
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_TICK,  4'd15, 1'b0, 4'd7,  1'b0,
          4'd0,  16'd0,    1'b0, '0},
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_TICK,  4'd15, 1'b1, 4'd8,  1'b0,
          4'd0,  16'd0,    1'b0, '0},
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_WRITE, 4'd0,  1'b0, 4'd0,  1'b0,
          4'd0,  16'hFFFF, 1'b0, '0},
        '{ROW_ITEM, ftdr_pkg::CFG_PPR,  ftdr_pkg::FUNC_TICK,  4'd15, 1'b1, 4'd8,  1'b1,
          4'd0,  16'd0,    1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    ftdr_in_if  in_ch ();
    ftdr_out_if out_ch ();
    ftdr_cfg_if cfg_ch ();

    fan_tach_duty_regulator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor copy of registers and state
    bit [7:0]    ppr_reg  = 8'd15;
    bit [11:0]   tol_reg  = 12'd50;
    bit [15:0]   win_reg  = 16'd1000;
    bit [11:0]   dmax_reg = 12'd1000;
    bit [15:0]   target_rpm [ftdr_pkg::LEVELS+1];
    int unsigned pulse_sum;
    int unsigned tick_count;
    bit [15:0]   rpm_meas;
    bit [11:0]   duty_cur;
    bit [11:0]   duty_out;
    int unsigned level_seen;
    bit          on_seen;

    ftdr_pkg::t_out_item status_q [$];
    int                  faults;
    bit                  calm;
    bit                  item_typed;
    ftdr_pkg::t_out_item item_want;

    // close a measurement window
    function automatic void take_reading();
        int unsigned divisor;
        int unsigned r;
        divisor = (ppr_reg == 0) ? 15 : ppr_reg;
        r = pulse_sum * 60 / divisor;
        rpm_meas = (r > 65535) ? 16'hFFFF : r[15:0];
        pulse_sum = 0;
        tick_count = 0;
    endfunction

    // advance the regulator state by one item and return its status
    function automatic ftdr_pkg::t_out_item regulate(input ftdr_pkg::t_in_item it);
        int unsigned         win_len;
        int unsigned         lvl;
        int unsigned         act_lvl;
        int unsigned         err_mag;
        int                  err;
        ftdr_pkg::t_out_item res;
        win_len = (win_reg == 0) ? 1 : win_reg;
        res = '0;
        if (it.func == ftdr_pkg::FUNC_WRITE) begin
            if (it.entry_index <= ftdr_pkg::LEVELS)
                target_rpm[it.entry_index] = it.entry_rpm;
        end else begin
            pulse_sum = pulse_sum + it.fg_pulses;
            if (pulse_sum > 20'hFFFFF)
                pulse_sum = 20'hFFFFF;
            if (tick_count < 65535)
                tick_count++;
            if (it.test_mode) begin
                if (tick_count >= win_len) begin
                    take_reading();
                    res.rpm_ready = 1'b1;
                end
            end else begin
                lvl = (it.speed_level >= ftdr_pkg::LEVELS) ? ftdr_pkg::LEVELS - 1
                                                           : it.speed_level;
                act_lvl = it.fan_on ? lvl : 0;
                if (!it.fan_on)
                    duty_cur = dmax_reg;
                // level or on change reloads duty and restarts the window
                if (act_lvl != level_seen || it.fan_on != on_seen) begin
                    level_seen = act_lvl;
                    on_seen = it.fan_on;
                    if (it.fan_on)
                        duty_cur = (LEVEL_DUTY[act_lvl] > dmax_reg) ? dmax_reg
                                                                     : LEVEL_DUTY[act_lvl];
                    pulse_sum = 0;
                    tick_count = 0;
                end
                if (tick_count >= win_len) begin
                    take_reading();
                    res.rpm_ready = 1'b1;
                    // one step towards the target of the next level
                    if (it.fan_on) begin
                        err = int'(rpm_meas) - int'(target_rpm[act_lvl + 1]);
                        err_mag = (err < 0) ? -err : err;
                        if (err_mag >= tol_reg) begin
                            if (err > 0) begin
                                if (duty_cur < dmax_reg)
                                    duty_cur++;
                            end else if (duty_cur > 0) begin
                                duty_cur--;
                            end
                        end
                    end
                end
                if (duty_cur != duty_out) begin
                    duty_out = duty_cur;
                    res.duty_update = 1'b1;
                end
            end
        end
        res.duty = duty_cur;
        res.fan_rpm = rpm_meas;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            faults++;
        end
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // accepted items feed the predictor
    always @(posedge i_clk) begin : watch_items
        ftdr_pkg::t_out_item predicted;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            predicted = regulate(in_ch.data);
            status_q.push_back(item_typed ? item_want : predicted);
        end
    end

    // register writes
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.data.index)
                ftdr_pkg::CFG_PPR:  ppr_reg  = cfg_ch.data.data[7:0];
                ftdr_pkg::CFG_TOL:  tol_reg  = cfg_ch.data.data[11:0];
                ftdr_pkg::CFG_WIN:  win_reg  = cfg_ch.data.data;
                ftdr_pkg::CFG_DMAX: dmax_reg = cfg_ch.data.data[11:0];
                default: ;
            endcase
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : watch_status
        ftdr_pkg::t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (status_q.size() == 0) begin
                $display("%0t: unexpected result duty %0d update %0d rpm %0d ready %0d",
                         $time, out_ch.data.duty, out_ch.data.duty_update,
                         out_ch.data.fan_rpm, out_ch.data.rpm_ready);
                faults++;
            end else begin
                want = status_q.pop_front();
                check_field("duty", 16'(want.duty), 16'(out_ch.data.duty));
                check_field("duty_update", 16'(want.duty_update),
                            16'(out_ch.data.duty_update));
                check_field("fan_rpm", want.fan_rpm, out_ch.data.fan_rpm);
                check_field("rpm_ready", 16'(want.rpm_ready), 16'(out_ch.data.rpm_ready));
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk)
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 14);

    // drive one item, with a random gap in front, and wait for its transfer
    task automatic send_item(input ftdr_pkg::t_in_item it, input bit typed,
                             input ftdr_pkg::t_out_item want);
        cfg_ch.valid <= 1'b0;
        while (!calm && $urandom_range(0, 99) < 14) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.data  <= it;
        in_ch.valid <= 1'b1;
        item_typed  <= typed;
        item_want   <= want;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input ftdr_pkg::t_cfg_reg creg, input logic [15:0] v);
        cfg_ch.data  <= '{index: creg, data: v};
        cfg_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stop sending and wait for every pending result
    task automatic quiesce();
        in_ch.valid  <= 1'b0;
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (status_q.size() != 0) @(negedge i_clk);
    endtask

    // watchdog
    initial begin : watchdog
        int unsigned n;
        for (n = 0; n < CYCLE_LIMIT; n++) @(posedge i_clk);
        $display("%0t: timeout with %0d results pending", $time, status_q.size());
        $display("FAIL fan_tach_duty_regulator");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        ftdr_pkg::t_in_item it;
        ftdr_pkg::t_cfg_reg creg;
        logic [15:0]        v;
        int unsigned        sent;
        int unsigned        phase;
        int unsigned        n_items;
        int unsigned        roll;
        int unsigned        change_pct;
        bit                 flood;
        bit                 prev_cfg;
        bit                 cur_on;
        bit [3:0]           cur_lvl;

        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        item_typed   = 1'b0;
        item_want    = '0;
        calm         = 1'b0;
        faults       = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        prev_cfg = 1'b0;
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                if (!prev_cfg)
                    quiesce();
                write_reg(DIRECTED[i].creg, DIRECTED[i].val);
                prev_cfg = 1'b1;
            end else begin
                it.func        = DIRECTED[i].func;
                it.fg_pulses   = DIRECTED[i].pulses;
                it.fan_on      = DIRECTED[i].on;
                it.speed_level = DIRECTED[i].lvl;
                it.test_mode   = DIRECTED[i].test;
                it.entry_index = DIRECTED[i].idx;
                it.entry_rpm   = DIRECTED[i].val;
                send_item(it, DIRECTED[i].typed, DIRECTED[i].want);
                prev_cfg = 1'b0;
            end
        end

        // random phases: new settings, then runs of steady level with noise
        sent = 0;
        phase = 0;
        cur_on = 1'b1;
        cur_lvl = 4'd0;
        while (sent < RANDOM_ITEMS) begin
            quiesce();
            flood = (phase == 3);
            creg = ftdr_pkg::CFG_PPR;
            repeat (creg.num()) begin
                roll = $urandom_range(0, 9);
                if (phase == 0 || $urandom_range(0, 1)) begin
                    case (creg)
                        ftdr_pkg::CFG_PPR:
                            v = (roll == 0) ? 16'd0 : (roll == 1) ? 16'd255 :
                                (roll == 2) ? 16'd1 : (roll == 3) ? 16'($urandom) :
                                16'($urandom_range(2, 30));
                        ftdr_pkg::CFG_TOL:
                            v = (roll == 0) ? 16'd0 : (roll == 1) ? 16'd4095 :
                                (roll == 2) ? 16'($urandom) :
                                16'($urandom_range(0, 200));
                        ftdr_pkg::CFG_WIN:
                            v = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF :
                                (roll <= 3) ? 16'($urandom_range(20, 60)) :
                                16'($urandom_range(1, 6));
                        default:
                            v = (roll == 0) ? 16'd0 : (roll == 1) ? 16'd4095 :
                                (roll == 2) ? 16'($urandom) :
                                16'($urandom_range(100, 1000));
                    endcase
                    write_reg(creg, v);
                end
                creg = creg.next();
            end
            // long window at one pulse per rev drives the rpm into saturation
            if (flood) begin
                write_reg(ftdr_pkg::CFG_PPR, 16'd1);
                write_reg(ftdr_pkg::CFG_WIN, 16'($urandom_range(80, 100)));
            end
            n_items = flood ? 130 : $urandom_range(20, 35);
            change_pct = flood ? 19 : 25;

            for (int k = 0; k < n_items && sent < RANDOM_ITEMS; k++) begin
                calm <= (sent >= 150 && sent < 250);
                roll = $urandom_range(0, 99);
                it.func        = ftdr_pkg::FUNC_TICK;
                it.fg_pulses   = flood ? 4'($urandom_range(10, 15))
                                       : 4'($urandom_range(0, 15));
                it.fan_on      = 1'($urandom_range(0, 1));
                it.speed_level = 4'($urandom_range(0, 15));
                it.test_mode   = 1'b0;
                it.entry_index = 4'($urandom_range(0, 15));
                it.entry_rpm   = 16'($urandom);
                if (roll < 10) begin
                    // target table write with noise in the tick fields
                    it.func        = ftdr_pkg::FUNC_WRITE;
                    it.test_mode   = 1'($urandom_range(0, 1));
                    it.entry_index = ($urandom_range(0, 9) < 8)
                                   ? 4'($urandom_range(0, ftdr_pkg::LEVELS))
                                   : 4'($urandom_range(ftdr_pkg::LEVELS + 1, 15));
                    if ($urandom_range(0, 1))
                        it.entry_rpm = 16'($urandom_range(0, 1500));
                end else if (roll < 18) begin
                    it.test_mode = 1'b1;
                end else begin
                    if (roll < change_pct) begin
                        cur_on  = ($urandom_range(0, 4) != 0);
                        cur_lvl = 4'($urandom_range(0, 15));
                    end
                    it.fan_on      = cur_on;
                    it.speed_level = cur_lvl;
                end
                send_item(it, 1'b0, '0);
                if (!(it.func == ftdr_pkg::FUNC_WRITE && it.entry_index > ftdr_pkg::LEVELS))
                    sent++;
            end
            phase++;
        end

        // drain and let the block settle
        calm <= 1'b0;
        quiesce();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (status_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, status_q.size());
            faults++;
        end
        if (faults == 0)
            $display("PASS fan_tach_duty_regulator");
        else
            $display("FAIL fan_tach_duty_regulator");
        $finish;
    end

endmodule
